>>> rtl/u8sd_pkg.sv
`default_nettype none
package u8sd_pkg;

	localparam int unsigned CP_W  = 21;
	localparam int unsigned LEN_W = 3;
	localparam int unsigned REP_W = 3;
	localparam int unsigned CNT_W = 2;
	localparam int unsigned PAY_W = 12;

	localparam logic [7:0] ASCII_LIMIT  = 8'h80;
	localparam logic [7:0] CONT_LO      = 8'h80;
	localparam logic [7:0] CONT_HI      = 8'hbf;
	localparam logic [7:0] LEAD2_LO     = 8'hc2;
	localparam logic [7:0] LEAD2_HI     = 8'hdf;
	localparam logic [7:0] LEAD3_LO     = 8'he0;
	localparam logic [7:0] LEAD3_HI     = 8'hef;
	localparam logic [7:0] LEAD4_LO     = 8'hf0;
	localparam logic [7:0] LEAD4_HI     = 8'hf4;
	localparam logic [7:0] LEAD_E0      = 8'he0;
	localparam logic [7:0] LEAD_ED      = 8'hed;
	localparam logic [7:0] LEAD_F0      = 8'hf0;
	localparam logic [7:0] LEAD_F4      = 8'hf4;
	localparam logic [7:0] E0_SECOND_LO = 8'ha0;
	localparam logic [7:0] ED_SECOND_HI = 8'h9f;
	localparam logic [7:0] F0_SECOND_LO = 8'h90;
	localparam logic [7:0] F4_SECOND_HI = 8'h8f;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(63);

	// Decoder state carried from byte to byte.
	typedef struct packed {
		logic [7:0]       lead;
		logic [CNT_W-1:0] count;
		logic [PAY_W-1:0] payload;
	} dec_state_t;

	// Results caused by one byte: rep replacements, then an optional tail item.
	typedef struct packed {
		logic [REP_W-1:0] rep;
		logic             tail;
		logic [CP_W-1:0]  cp;
		logic [LEN_W-1:0] len;
		logic             text_end;
	} burst_t;

	// Sequence length opened by a lead byte, zero when it opens none.
	function automatic logic [LEN_W-1:0] seq_length(input logic [7:0] lead);
		logic [LEN_W-1:0] n;
		n = '0;
		if (lead >= LEAD2_LO && lead <= LEAD2_HI) n = LEN_W'(2);
		else if (lead >= LEAD3_LO && lead <= LEAD3_HI) n = LEN_W'(3);
		else if (lead >= LEAD4_LO && lead <= LEAD4_HI) n = LEN_W'(4);
		return n;
	endfunction

endpackage
`default_nettype wire

>>> rtl/u8sd_decode.sv
`default_nettype none
module u8sd_decode import u8sd_pkg::*; (
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire dec_state_t cur,
	output dec_state_t      nxt,
	output burst_t          burst
);

	logic [LEN_W-1:0] need;
	logic [LEN_W-1:0] fresh_len;
	logic [7:0]       lo;
	logic [7:0]       hi;
	logic             held;
	logic             cont_ok;
	logic             complete;
	logic [CP_W-1:0]  lead_part;
	logic [CP_W-1:0]  joined_cp;

	assign held      = (cur.count != '0);
	assign need      = seq_length(cur.lead);
	assign fresh_len = seq_length(in_byte);

	// The second byte of a sequence has a narrowed range; that is where overlong
	// forms, surrogates and values above the last plane get rejected.
	always_comb begin
		lo = CONT_LO;
		hi = CONT_HI;
		if (cur.count == CNT_W'(1)) begin
			unique case (cur.lead)
				LEAD_E0: lo = E0_SECOND_LO;
				LEAD_ED: hi = ED_SECOND_HI;
				LEAD_F0: lo = F0_SECOND_LO;
				LEAD_F4: hi = F4_SECOND_HI;
				default: ;
			endcase
		end
	end

	assign cont_ok  = held && (need != '0) && (in_byte >= lo) && (in_byte <= hi);
	assign complete = cont_ok && ({1'b0, cur.count} + LEN_W'(1) == need);

	always_comb begin
		unique case (need)
			LEN_W'(2): lead_part = CP_W'({cur.lead[4:0], 6'b0});
			LEN_W'(3): lead_part = CP_W'({cur.lead[3:0], 12'b0});
			LEN_W'(4): lead_part = CP_W'({cur.lead[2:0], 18'b0});
			default:   lead_part = '0;
		endcase
	end

	assign joined_cp = lead_part | CP_W'({cur.payload, 6'b0}) | CP_W'(in_byte[5:0]);

	always_comb begin
		nxt             = cur;
		burst.rep       = '0;
		burst.tail      = 1'b0;
		burst.cp        = REPLACEMENT_CP;
		burst.len       = LEN_W'(1);
		burst.text_end  = in_last;
		if (complete) begin
			burst.tail = 1'b1;
			burst.cp   = joined_cp;
			burst.len  = need;
			nxt        = '0;
		end else if (cont_ok) begin
			nxt.payload = PAY_W'({cur.payload, in_byte[5:0]});
			nxt.count   = cur.count + CNT_W'(1);
			// The string ends inside the sequence: every held byte and this one turn into '?'.
			if (in_last) begin
				burst.rep = REP_W'(cur.count) + REP_W'(1);
			end
		end else begin
			// Broken or no sequence: flush what is held, then decode the byte fresh.
			burst.rep = REP_W'(cur.count);
			nxt       = '0;
			if (in_byte < ASCII_LIMIT) begin
				burst.tail = 1'b1;
				burst.cp   = CP_W'(in_byte);
			end else if (fresh_len == '0) begin
				burst.tail = 1'b1;
			end else if (in_last) begin
				burst.rep = burst.rep + REP_W'(1);
			end else begin
				nxt.lead  = in_byte;
				nxt.count = CNT_W'(1);
			end
		end
		if (in_last) begin
			nxt = '0;
		end
	end

endmodule
`default_nettype wire

>>> rtl/utf8_stream_decoder.sv
`default_nettype none
// Strict UTF-8 to code point stream decoder.
//
// The slave channel takes one byte of text per request: s_tdata carries the
// byte and s_tlast marks the final byte of a string, so no terminator is sent.
// The master channel returns one code point per request, with the number of
// bytes it used; m_tuser is high on the last result caused by an input byte
// and m_tlast is high on the final result of the whole string.
//
// A byte is registered in an input stage, decoded there in one pass, and the
// results it causes are loaded into an output stage, from which they show on
// the master channel; a byte with results waits in the input stage while the
// output stage is busy. A byte that causes one result leaves room for the next
// byte in every cycle while m_tready is high, so well-formed text flows at one
// byte per cycle. A rejected sequence can give up to four '?' results; the
// output stage sends one per cycle while m_tready is high, and a byte waiting
// in the input stage behind a burst is held until its last result is taken.
// A byte that only extends an open sequence gives nothing.
//
// Reset clears both stages and the held sequence. When the receiver holds
// m_tready low, the output stage keeps its result and s_tready falls once the
// input stage holds a byte that still needs the output stage.
module utf8_stream_decoder import u8sd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,   // in_last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] byte_length
	output logic             m_tuser,   // run_last
	output logic             m_tlast    // text_end
);

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Sequence held between bytes.
	dec_state_t state_q;
	dec_state_t state_next;
	burst_t     burst;

	// Output stage: a count of pending replacements and an optional tail item.
	logic             valid_s2;
	logic [REP_W-1:0] rep_s2;
	logic             tail_s2;
	logic [CP_W-1:0]  cp_s2;
	logic [LEN_W-1:0] len_s2;
	logic             end_s2;

	logic burst_empty;
	logic out_final;
	logic out_done;
	logic out_free;
	logic advance;

	u8sd_decode u_decode (
		.in_byte (byte_s1),
		.in_last (last_s1),
		.cur     (state_q),
		.nxt     (state_next),
		.burst   (burst)
	);

	assign burst_empty = (burst.rep == '0) && !burst.tail;

	// The current result is the last of its burst when only the tail remains,
	// or when the final replacement goes out and no tail follows.
	assign out_final = (rep_s2 == '0) || ((rep_s2 == REP_W'(1)) && !tail_s2);
	assign out_done  = valid_s2 && m_tready;
	assign out_free  = !valid_s2 || (m_tready && out_final);
	assign advance   = valid_s1 && (burst_empty || out_free);
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			rep_s2   <= '0;
			tail_s2  <= 1'b0;
		end else if (advance && !burst_empty) begin
			valid_s2 <= 1'b1;
			rep_s2   <= burst.rep;
			tail_s2  <= burst.tail;
		end else if (out_done && out_final) begin
			valid_s2 <= 1'b0;
		end else if (out_done) begin
			rep_s2 <= rep_s2 - REP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !burst_empty) begin
			cp_s2  <= burst.cp;
			len_s2 <= burst.len;
			end_s2 <= burst.text_end;
		end
	end

	// Pending replacements go out before the tail item.
	always_comb begin
		if (rep_s2 != '0) begin
			m_tdata = {LEN_W'(1), REPLACEMENT_CP};
		end else begin
			m_tdata = {len_s2, cp_s2};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = out_final;
	assign m_tlast  = out_final && end_s2;

endmodule
`default_nettype wire

>>> rtl/u8sd_checker.sv
`default_nettype none
module u8sd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	// The end of a string is always also the last result of its byte.
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("text end without run end");

	// Byte count stays within one to four.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:21] != 3'd0) && (m_tdata[23:21] <= 3'd4))
		else $error("byte count out of range");

	// Single-byte results are plain ASCII or the replacement character.
	a_single_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[23:21] == 3'd1) |-> (m_tdata[20:7] == 14'd0))
		else $error("single-byte result above ASCII");

	// Multi-byte results never decode to an ASCII value or a surrogate.
	a_multi_strict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[23:21] != 3'd1) |->
			(m_tdata[20:7] != 14'd0) && (m_tdata[20:11] != 10'h01b))
		else $error("overlong or surrogate result");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
